/* design/ghn_pkg.sv */
`timescale 1ns / 1ps
package ghn_pkg;

  localparam int NORM_W   = 16;
  localparam int ROWS_W   = 9;
  localparam int Q_W      = 24;
  localparam int SCALE_W  = 16;
  localparam int DEN_W    = Q_W + 1;
  localparam int T_W      = Q_W + 1 + SCALE_W;
  localparam int MAG_W    = NORM_W;
  localparam int ACC_W    = T_W + MAG_W;
  localparam int FRAC_W   = 30;
  localparam int F_W      = ACC_W - FRAC_W + 1;
  localparam int STEP_W   = $clog2(T_W);
  localparam int BIN_W    = 16;
  localparam int COUNT_W  = 24;
  localparam int CELLS_W  = 2 * ROWS_W;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ACCUM = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_CENTER = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  localparam logic [ROWS_W-1:0] ROWS_RESET   = ROWS_W'(64);
  localparam logic [Q_W-1:0]    CENTER_RESET = Q_W'(65536);
  localparam logic [Q_W-1:0]    OFFSET_RESET = Q_W'(65536);

  typedef struct packed {
    logic [1:0]               action;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic                     read_south;
    logic [BIN_W-1:0]         read_bin;
  } ghn_in_t;

  typedef struct packed {
    logic [BIN_W-1:0]   bin_index;
    logic               in_south;
    logic               out_of_range;
    logic [COUNT_W-1:0] bin_count;
  } ghn_out_t;

  typedef struct packed {
    logic [ROWS_W-1:0] grid_rows;
    logic [Q_W-1:0]    proj_center;
    logic [Q_W-1:0]    plane_offset;
  } ghn_cfg_t;

  typedef struct packed {
    logic                     go;
    logic [Q_W-1:0]           alpha;
    logic [Q_W-1:0]           beta;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
  } ghn_arith_req_t;

  typedef struct packed {
    logic                done;
    logic                den_zero;
    logic signed [F_W-1:0] fx;
    logic signed [F_W-1:0] fy;
  } ghn_arith_rsp_t;

endpackage

/* design/ghn_ram.sv */
`timescale 1ns / 1ps
module ghn_ram #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* design/ghn_apb.sv */
`timescale 1ns / 1ps
module ghn_apb import ghn_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output ghn_cfg_t           cfg
);

  logic [1:0] reg_idx;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_rows    <= ROWS_RESET;
      cfg.proj_center  <= CENTER_RESET;
      cfg.plane_offset <= OFFSET_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ROWS:   cfg.grid_rows    <= pwdata[ROWS_W-1:0];
        REG_CENTER: cfg.proj_center  <= pwdata[Q_W-1:0];
        REG_OFFSET: cfg.plane_offset <= pwdata[Q_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROWS:   prdata = PDATA_W'(cfg.grid_rows);
      REG_CENTER: prdata = PDATA_W'(cfg.proj_center);
      REG_OFFSET: prdata = PDATA_W'(cfg.plane_offset);
      default:    prdata = '0;
    endcase
  end

endmodule

/* design/ghn_arith.sv */
`timescale 1ns / 1ps
module ghn_arith import ghn_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  ghn_arith_req_t req,
  output ghn_arith_rsp_t rsp
);

  typedef enum logic [5:0] {
    A_IDLE = 6'b000001,
    A_DIV  = 6'b000010,
    A_MULX = 6'b000100,
    A_FINX = 6'b001000,
    A_MULY = 6'b010000,
    A_FINY = 6'b100000
  } arith_state_t;

  arith_state_t          state;
  logic [STEP_W-1:0]     step;
  logic [DEN_W-1:0]      rem;
  logic [DEN_W-1:0]      den;
  logic [T_W-1:0]        qn;
  logic [ACC_W-1:0]      acc;
  logic [MAG_W-1:0]      mop;
  logic [MAG_W-1:0]      mx;
  logic [MAG_W-1:0]      my;
  logic                  sx;
  logic                  sy;
  logic                  finished;
  logic                  den_zero;
  logic signed [F_W-1:0] fx;
  logic signed [F_W-1:0] fy;

  logic [DEN_W:0]        rem_sh;
  logic [ACC_W-1:0]      add_a;
  logic [ACC_W-1:0]      add_b;
  logic                  add_cin;
  logic [ACC_W-1:0]      add_sum;
  logic                  q_bit;
  logic [MAG_W-1:0]      abs_x;
  logic [MAG_W-1:0]      abs_y;
  logic [MAG_W-1:0]      abs_z;
  logic [DEN_W-1:0]      den_in;
  logic [T_W-1:0]        num_in;
  logic                  div_last;
  logic                  mul_last;

  function automatic logic signed [F_W-1:0] to_floor(input logic [ACC_W-1:0] mag,
                                                     input logic neg);
    logic [F_W-1:0] hi;
    hi = F_W'(mag[ACC_W-1:FRAC_W]) + F_W'(neg && (|mag[FRAC_W-1:0]));
    return neg ? $signed(~hi + 1'b1) : $signed(hi);
  endfunction

  assign abs_x  = req.norm_x[NORM_W-1] ? MAG_W'(~req.norm_x + 1'b1) : MAG_W'(req.norm_x);
  assign abs_y  = req.norm_y[NORM_W-1] ? MAG_W'(~req.norm_y + 1'b1) : MAG_W'(req.norm_y);
  assign abs_z  = req.norm_z[NORM_W-1] ? MAG_W'(~req.norm_z + 1'b1) : MAG_W'(req.norm_z);
  assign den_in = DEN_W'(req.alpha) + DEN_W'({abs_z, 2'b00});
  assign num_in = {DEN_W'(req.alpha) + DEN_W'(req.beta), SCALE_W'(0)};

  assign rem_sh   = {rem, qn[T_W-1]};
  assign div_last = (step == STEP_W'(T_W - 1));
  assign mul_last = (step == STEP_W'(MAG_W - 1));

  assign rsp = '{done: finished, den_zero: den_zero, fx: fx, fy: fy};

  // The one adder serves as the trial subtractor of the division and as the
  // accumulator of the shift-and-add multiplications.
  always_comb begin
    if (state == A_DIV) begin
      add_a   = ACC_W'(rem_sh);
      add_b   = ~ACC_W'(den);
      add_cin = 1'b1;
    end else begin
      add_a   = {acc[ACC_W-2:0], 1'b0};
      add_b   = mop[MAG_W-1] ? ACC_W'(qn) : '0;
      add_cin = 1'b0;
    end
    add_sum = add_a + add_b + ACC_W'(add_cin);
    q_bit   = ~add_sum[ACC_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= A_IDLE;
      step     <= '0;
      finished <= 1'b0;
    end else begin
      finished <= (state == A_FINY);
      unique case (state)
        A_IDLE: begin
          step <= '0;
          if (req.go) begin
            state <= A_DIV;
          end
        end
        A_DIV: begin
          if (div_last) begin
            state <= A_MULX;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        A_MULX: begin
          if (mul_last) begin
            state <= A_FINX;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        A_FINX: state <= A_MULY;
        A_MULY: begin
          if (mul_last) begin
            state <= A_FINY;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        A_FINY: state <= A_IDLE;
        default: state <= A_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      A_IDLE: begin
        if (req.go) begin
          rem      <= '0;
          qn       <= num_in;
          den      <= den_in;
          den_zero <= (den_in == '0);
          mx       <= abs_x;
          my       <= abs_y;
          sx       <= req.norm_x[NORM_W-1];
          sy       <= req.norm_y[NORM_W-1];
        end
      end
      A_DIV: begin
        rem <= q_bit ? add_sum[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        qn  <= {qn[T_W-2:0], q_bit};
        acc <= '0;
        mop <= mx;
      end
      A_MULX, A_MULY: begin
        acc <= add_sum;
        mop <= {mop[MAG_W-2:0], 1'b0};
      end
      A_FINX: begin
        fx  <= to_floor(acc, sx);
        acc <= '0;
        mop <= my;
      end
      A_FINY: fy <= to_floor(acc, sy);
      default: ;
    endcase
  end

endmodule

/* design/gauss_sphere_normal_histogram.sv */
`timescale 1ns / 1ps
// Stereographic Gauss-map histogram. A command is taken when start is high
// and busy is low, and its one result appears on result for a single cycle
// with done high; the receiver cannot hold it off. An accumulate command
// runs 41 steps of the restoring division for the scale factor and two
// 16-step shift-and-add multiplications, all on one shared 57-bit adder,
// then the grid index and a read-modify-write of one counter. An in-range
// read passes through its read state, while an unused code or an
// out-of-range read is answered straight from idle. A clear sweeps both
// banks one entry per cycle, and the same sweep runs after reset, during
// which no command is taken but configuration writes are.
module gauss_sphere_normal_histogram import ghn_pkg::*; #(
  parameter int MAX_ROWS   = 256,
  parameter int COUNT_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ghn_in_t            cmd,
  output logic               done,
  output ghn_out_t           result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int DEPTH  = MAX_ROWS * MAX_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PY_W   = ROWS_W + 1 + F_W;
  localparam int SUM_W  = PY_W + 1;
  localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [7:0] {
    S_SWEEP = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_READ  = 8'b00000100,
    S_CALC  = 8'b00001000,
    S_SCALE = 8'b00010000,
    S_BIN   = 8'b00100000,
    S_LOOK  = 8'b01000000,
    S_INC   = 8'b10000000
  } state_t;

  state_t                  state;
  state_t                  state_next;
  logic [ADDR_W-1:0]       sweep_addr;
  logic                    sweep_report;
  ghn_in_t                 item;
  logic signed [PY_W-1:0]  prod_y;
  logic                    bin_ok_r;
  logic [ADDR_W-1:0]       idx_r;

  ghn_cfg_t                cfg;
  ghn_arith_req_t          req;
  ghn_arith_rsp_t          rsp;
  logic [ROWS_W-1:0]       rows;
  logic [CELLS_W-1:0]      cells;
  logic [CELLS_W-1:0]      half;
  logic signed [SUM_W-1:0] bin;
  logic                    bin_ok;
  logic [ADDR_W-1:0]       idx;
  logic                    rd_ok;
  logic                    accept;
  logic                    south;
  logic [ADDR_W-1:0]       ram_addr;
  logic                    we_n;
  logic                    we_s;
  logic [COUNT_BITS-1:0]   wdata;
  logic [COUNT_BITS-1:0]   rdata_n;
  logic [COUNT_BITS-1:0]   rdata_s;
  logic [COUNT_BITS-1:0]   cnt;
  ghn_out_t                res_next;

  ghn_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ghn_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  ghn_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(COUNT_BITS)) u_ram_north (
    .clk   (clk),
    .we    (we_n),
    .addr  (ram_addr),
    .wdata (wdata),
    .rdata (rdata_n)
  );

  ghn_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(COUNT_BITS)) u_ram_south (
    .clk   (clk),
    .we    (we_s),
    .addr  (ram_addr),
    .wdata (wdata),
    .rdata (rdata_s)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  assign req = '{go:     accept && (cmd.action == ACT_ACCUM),
                 alpha:  cfg.proj_center,
                 beta:   cfg.plane_offset,
                 norm_x: cmd.norm_x,
                 norm_y: cmd.norm_y,
                 norm_z: cmd.norm_z};

  assign rows  = (int'(cfg.grid_rows) > MAX_ROWS) ? ROWS_W'(MAX_ROWS) : cfg.grid_rows;
  assign cells = CELLS_W'(rows) * CELLS_W'(rows);
  assign half  = cells >> 1;
  assign rd_ok = (CELLS_W'(cmd.read_bin) < cells) && (int'(cmd.read_bin) < DEPTH);
  assign south = item.norm_z[NORM_W-1];

  assign bin    = SUM_W'(prod_y) + SUM_W'(rsp.fx) + SUM_W'(half);
  assign bin_ok = !bin[SUM_W-1] && (bin[SUM_W-2:0] < (SUM_W-1)'(cells));
  assign idx    = ADDR_W'(bin) & LAST_ADDR;

  assign cnt = south ? rdata_s : rdata_n;

  always_comb begin
    ram_addr = ADDR_W'(cmd.read_bin);
    we_n     = 1'b0;
    we_s     = 1'b0;
    wdata    = (cnt == COUNT_MAX) ? cnt : cnt + 1'b1;
    unique case (state)
      S_SWEEP: begin
        ram_addr = sweep_addr;
        we_n     = 1'b1;
        we_s     = 1'b1;
        wdata    = '0;
      end
      S_LOOK: ram_addr = idx_r;
      S_INC: begin
        ram_addr = idx_r;
        we_n     = !south;
        we_s     = south;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_SWEEP: begin
        if (sweep_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          priority if (cmd.action == ACT_CLEAR) begin
            state_next = S_SWEEP;
          end else if (cmd.action == ACT_ACCUM) begin
            state_next = S_CALC;
          end else if (cmd.action == ACT_READ && rd_ok) begin
            state_next = S_READ;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_READ:  state_next = S_IDLE;
      S_CALC: begin
        if (rsp.done) begin
          state_next = rsp.den_zero ? S_IDLE : S_SCALE;
        end
      end
      S_SCALE: state_next = S_BIN;
      S_BIN:   state_next = S_LOOK;
      S_LOOK:  state_next = bin_ok_r ? S_INC : S_IDLE;
      S_INC:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    res_next = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd.action == ACT_READ) begin
          res_next.bin_index    = cmd.read_bin;
          res_next.in_south     = cmd.read_south;
          res_next.out_of_range = 1'b1;
        end
      end
      S_READ: begin
        res_next.bin_index = item.read_bin;
        res_next.in_south  = item.read_south;
        res_next.bin_count = COUNT_W'(item.read_south ? rdata_s : rdata_n);
      end
      S_CALC, S_LOOK: begin
        res_next.in_south     = south;
        res_next.out_of_range = 1'b1;
      end
      S_INC: begin
        res_next.bin_index = BIN_W'(idx_r);
        res_next.in_south  = south;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      sweep_addr   <= '0;
      sweep_report <= 1'b0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          done       <= sweep_report && (sweep_addr == LAST_ADDR);
          if (sweep_addr == LAST_ADDR) begin
            sweep_report <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            priority if (cmd.action == ACT_CLEAR) begin
              sweep_addr   <= '0;
              sweep_report <= 1'b1;
              done         <= 1'b0;
            end else if (cmd.action == ACT_ACCUM) begin
              done <= 1'b0;
            end else if (cmd.action == ACT_READ) begin
              done <= !rd_ok;
            end else begin
              done <= 1'b1;
            end
          end else begin
            done <= 1'b0;
          end
        end
        S_READ, S_INC: done <= 1'b1;
        S_CALC:        done <= rsp.done && rsp.den_zero;
        S_LOOK:        done <= !bin_ok_r;
        default:       done <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= cmd;
    end
    if (state == S_SCALE) begin
      prod_y <= $signed({1'b0, rows}) * rsp.fy;
    end
    if (state == S_BIN) begin
      bin_ok_r <= bin_ok;
      idx_r    <= idx;
    end
    result <= res_next;
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result strobe without a command in progress");

  a_accept_answered: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither in progress nor answered");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !(we_n || we_s))
    else $error("counter memory written while idle");

  a_range_no_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.out_of_range) |-> (result.bin_count == '0))
    else $error("out-of-range result carries a count");

endmodule

/* test/gauss_sphere_normal_histogram_tb.sv */
`timescale 1ns / 1ps
module gauss_sphere_normal_histogram_tb;
  import ghn_pkg::*;

  localparam int GRID_MAX    = 256;
  localparam int BANK_DEPTH  = GRID_MAX * GRID_MAX;
  localparam int QUIET_LIMIT = 300000;
  localparam int HIT_KEEP    = 16;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  ghn_in_t            cmd     = '0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic               busy;
  logic               done;
  ghn_out_t           result;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  gauss_sphere_normal_histogram #(
    .MAX_ROWS  (GRID_MAX),
    .COUNT_BITS(COUNT_W)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk = ~clk;

  logic [COUNT_W-1:0] north_bins [BANK_DEPTH];
  logic [COUNT_W-1:0] south_bins [BANK_DEPTH];
  logic [ROWS_W-1:0]  rows_setting   = ROWS_RESET;
  logic [Q_W-1:0]     alpha_setting  = CENTER_RESET;
  logic [Q_W-1:0]     beta_setting   = OFFSET_RESET;

  ghn_in_t    cmd_backlog [$];
  ghn_out_t   due_results [$];
  logic [16:0] hit_log [$];

  logic cmd_taken = 1'b0;
  logic gaps_on   = 1'b1;
  int   gap_left  = 0;
  int   calm_left = 0;
  int   quiet     = 0;
  int   fails     = 0;
  int   n_clear   = 0;
  int   n_accum   = 0;
  int   n_read    = 0;
  int   n_spare   = 0;
  int   n_checked = 0;
  int   n_counted = 0;
  int   n_settings = 1;

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    fails++;
    $display("[%0t] wrong %s: got %0d, wanted %0d", $realtime, what, got, want);
  endtask

  function automatic void queue_cmd(input ghn_in_t c);
    cmd_backlog.insert(cmd_backlog.size(), c);
  endfunction

  function automatic void wipe_banks();
    for (int i = 0; i < BANK_DEPTH; i++) begin
      north_bins[i] = '0;
      south_bins[i] = '0;
    end
  endfunction

  function automatic longint active_rows();
    return (rows_setting > GRID_MAX) ? GRID_MAX : longint'(rows_setting);
  endfunction

  // Stereographic scale t = (alpha + beta) / (alpha + 4|z|) in Q.16, then the
  // floored Q.30 products give the grid offsets from the centre cell.
  function automatic void locate_bin(input ghn_in_t c, output logic oor,
                                     output logic [BIN_W-1:0] idx);
    longint rows, cells, sx, sy, sz, den, t, fx, fy, flat;
    rows = active_rows();
    cells = rows * rows;
    sx = $signed(c.norm_x);
    sy = $signed(c.norm_y);
    sz = $signed(c.norm_z);
    den = longint'(alpha_setting) + ((sz < 0 ? -sz : sz) * 4);
    oor = 1'b1;
    idx = '0;
    if (den != 0) begin
      t = ((longint'(alpha_setting) + longint'(beta_setting)) * 65536) / den;
      fx = (t * sx) >>> 30;
      fy = (t * sy) >>> 30;
      flat = rows * fy + cells / 2 + fx;
      if (flat >= 0 && flat < cells) begin
        oor = 1'b0;
        idx = flat[BIN_W-1:0];
      end
    end
  endfunction

  function automatic ghn_out_t apply_command(input ghn_in_t c);
    ghn_out_t r;
    logic oor;
    logic [BIN_W-1:0] idx;
    r = '0;
    case (c.action)
      ACT_CLEAR: wipe_banks();
      ACT_ACCUM: begin
        r.in_south = c.norm_z[NORM_W-1];
        locate_bin(c, oor, idx);
        r.out_of_range = oor;
        if (!oor) begin
          r.bin_index = idx;
          n_counted++;
          if (r.in_south) begin
            if (south_bins[idx] != '1) south_bins[idx]++;
          end else begin
            if (north_bins[idx] != '1) north_bins[idx]++;
          end
        end
      end
      ACT_READ: begin
        r.bin_index = c.read_bin;
        r.in_south = c.read_south;
        if (longint'(c.read_bin) >= active_rows() * active_rows()) begin
          r.out_of_range = 1'b1;
        end else begin
          r.bin_count = c.read_south ? south_bins[c.read_bin] : north_bins[c.read_bin];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic ghn_in_t plain_command(input logic [1:0] action);
    ghn_in_t c;
    c = ghn_in_t'(67'({$urandom, $urandom, $urandom}));
    c.action = action;
    return c;
  endfunction

  function automatic ghn_in_t accum(input logic [15:0] x, input logic [15:0] y,
                                    input logic [15:0] z);
    ghn_in_t c;
    logic oor;
    logic [BIN_W-1:0] idx;
    c = plain_command(ACT_ACCUM);
    c.norm_x = x;
    c.norm_y = y;
    c.norm_z = z;
    locate_bin(c, oor, idx);
    if (!oor) begin
      hit_log.insert(hit_log.size(), {z[15], idx});
      if (hit_log.size() > HIT_KEEP) void'(hit_log.pop_front());
    end
    return c;
  endfunction

  function automatic ghn_in_t read_cmd(input logic south, input logic [BIN_W-1:0] bin);
    ghn_in_t c;
    c = plain_command(ACT_READ);
    c.read_south = south;
    c.read_bin = bin;
    return c;
  endfunction

  function automatic logic [15:0] pick_component(input int mode);
    case (mode)
      0, 1:    return 16'($urandom_range(0, 32768)) - 16'd16384;
      2:       return 16'($urandom);
      3:       return 16'($urandom_range(0, 128)) - 16'd64;
      default: return 16'($urandom_range(0, 2)) - 16'd1;
    endcase
  endfunction

  function automatic ghn_in_t random_command();
    int pick, mode;
    logic [16:0] hit;
    longint cells;
    pick = $urandom_range(0, 999);
    cells = active_rows() * active_rows();
    if (pick < 2) return plain_command(ACT_CLEAR);
    if (pick < 40) return plain_command(ACT_SPARE);
    if (pick < 560) begin
      mode = $urandom_range(0, 4);
      return accum(pick_component(mode == 4 ? 0 : mode),
                   pick_component(mode == 4 ? 0 : mode), pick_component(mode));
    end
    if (pick < 800 && hit_log.size() != 0) begin
      hit = hit_log[$urandom_range(0, hit_log.size() - 1)];
      return read_cmd(hit[16], hit[15:0]);
    end
    if (pick < 900) begin
      return read_cmd(1'($urandom_range(0, 1)),
                      16'($urandom_range(0, cells > 0 ? int'(cells - 1) : 0)));
    end
    return read_cmd(1'($urandom_range(0, 1)), 16'($urandom));
  endfunction

  task automatic fill(input int count);
    for (int i = 0; i < count; i++) queue_cmd(random_command());
  endtask

  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (cmd_backlog.size() != 0 || start || due_results.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ROWS:   rows_setting = val[ROWS_W-1:0];
      REG_CENTER: alpha_setting = val[Q_W-1:0];
      REG_OFFSET: beta_setting = val[Q_W-1:0];
      default: ;
    endcase
  endtask

  // Upper data bits are filled with noise; the registers keep only their width.
  task automatic set_grid(input int rows, input int alpha, input int beta);
    settle();
    write_reg(REG_ROWS, ($urandom & ~32'h1FF) | 32'(rows));
    write_reg(REG_CENTER, ($urandom & 32'hFF00_0000) | 32'(alpha));
    write_reg(REG_OFFSET, ($urandom & 32'hFF00_0000) | 32'(beta));
    n_settings++;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !cmd_taken) begin
      start <= 1'b1;
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (cmd_backlog.size() != 0) begin
      if (gaps_on && calm_left == 0 && $urandom_range(0, 3) == 0) begin
        gap_left <= $urandom_range(0, 11);
        start <= 1'b0;
      end else begin
        cmd <= cmd_backlog.pop_front();
        start <= 1'b1;
        if (calm_left != 0) begin
          calm_left <= calm_left - 1;
        end else if ($urandom_range(0, 15) == 0) begin
          calm_left <= $urandom_range(8, 40);
        end
      end
    end else begin
      start <= 1'b0;
    end
  end

  ghn_out_t wanted;

  always @(posedge clk) begin
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= start && !busy;
      if (done) begin
        n_checked++;
        if (due_results.size() == 0) begin
          flag_mismatch("transfer with no result due, bin_index", result.bin_index, -1);
        end else begin
          wanted = due_results.pop_front();
          if (result.bin_index !== wanted.bin_index)
            flag_mismatch("bin_index", result.bin_index, wanted.bin_index);
          if (result.in_south !== wanted.in_south)
            flag_mismatch("in_south", result.in_south, wanted.in_south);
          if (result.out_of_range !== wanted.out_of_range)
            flag_mismatch("out_of_range", result.out_of_range, wanted.out_of_range);
          if (result.bin_count !== wanted.bin_count)
            flag_mismatch("bin_count", result.bin_count, wanted.bin_count);
        end
      end
      if (start && !busy) begin
        case (cmd.action)
          ACT_CLEAR: n_clear++;
          ACT_ACCUM: n_accum++;
          ACT_READ:  n_read++;
          default:   n_spare++;
        endcase
        due_results.insert(due_results.size(), apply_command(cmd));
      end
      if ((start && !busy) || done) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("Watchdog expired after %0d cycles without a transfer.", quiet);
        $display("gauss_sphere_normal_histogram: mismatch");
        $finish;
      end
    end
  end

  initial begin
    wipe_banks();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    queue_cmd(read_cmd(1'b0, 16'd2048));
    queue_cmd(accum(16'sd0, 16'sd0, 16'sd16384));
    queue_cmd(accum(16'sd16384, -16'sd16384, -16'sd16384));
    queue_cmd(accum(-16'sd32768, 16'sd32767, 16'sd0));
    queue_cmd(accum(16'sd16384, 16'sd16384, 16'sd0));
    queue_cmd(accum(16'sd0, 16'sd0, -16'sd32768));
    queue_cmd(accum(-16'sd1, -16'sd1, 16'sd1));
    queue_cmd(accum(16'sd32767, -16'sd32768, -16'sd1));
    queue_cmd(accum(16'sd0, 16'sd0, 16'sd16384));
    queue_cmd(read_cmd(1'b0, 16'd2048));
    queue_cmd(read_cmd(1'b1, 16'd1985));
    queue_cmd(read_cmd(1'b0, 16'd0));
    queue_cmd(read_cmd(1'b0, 16'd4095));
    queue_cmd(read_cmd(1'b1, 16'd4096));
    queue_cmd(read_cmd(1'b1, 16'hFFFF));
    queue_cmd(plain_command(ACT_SPARE));
    queue_cmd(plain_command(ACT_CLEAR));
    queue_cmd(read_cmd(1'b0, 16'd2048));
    queue_cmd(accum(16'sd0, 16'sd0, 16'sd0));
    queue_cmd(read_cmd(1'b0, 16'd2048));
    fill(180);

    set_grid(2, 1, 0);
    fill(200);
    set_grid(256, 65536, 65536);
    fill(200);
    set_grid(511, 24'hFFFFFF, 24'hFFFFFF);
    fill(200);
    set_grid(0, 65536, 0);
    fill(100);
    set_grid(64, 0, 24'hFFFFFF);
    queue_cmd(accum(16'sd5, -16'sd5, 16'sd0));
    queue_cmd(accum(16'sd100, 16'sd100, -16'sd1));
    fill(150);
    for (int k = 0; k < 2; k++) begin
      set_grid($urandom_range(2, 256), $urandom_range(4096, 1 << 20),
               $urandom_range(0, 1 << 20));
      fill(130);
    end
    set_grid(64, 65536, 65536);
    gaps_on = 1'b0;
    fill(150);

    settle();
    repeat (100) @(posedge clk);
    $display("Ran %0d accumulates (%0d landed in the grid), %0d reads, %0d clears and %0d",
             n_accum, n_counted, n_read, n_clear, n_spare);
    $display("unused codes across %0d grid settings; %0d results were compared.",
             n_settings, n_checked);
    if (fails == 0) begin
      $display("gauss_sphere_normal_histogram: match");
    end else begin
      $display("gauss_sphere_normal_histogram: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
design/ghn_pkg.sv
design/ghn_ram.sv
design/ghn_apb.sv
design/ghn_arith.sv
design/gauss_sphere_normal_histogram.sv
test/gauss_sphere_normal_histogram_tb.sv
